// ===== src/mtce_pkg.sv =====
package mtce_pkg;

  // graph size limits
  localparam int MAX_VERTS = 16;
  localparam int MAX_EDGES = 32;

  // real vertices plus one virtual vertex numbered above them
  localparam int NODES = MAX_VERTS + 1;
  localparam int VIRT  = MAX_VERTS;

  // fixed field widths of the item formats
  localparam int FIELD_W = 5;
  localparam int TOTAL_W = 4;
  localparam int TRAIL_W = 3;

  // derived storage widths and depths
  // every real edge plus one virtual edge per odd vertex can sit on the walk
  localparam int CNT_W       = $clog2(2 * MAX_EDGES + 2);
  localparam int NODE_W      = $clog2(NODES);
  localparam int VIDX_W      = $clog2(MAX_VERTS);
  localparam int EDGE_W      = $clog2(MAX_EDGES + 1);
  localparam int STACK_DEPTH = MAX_EDGES + MAX_VERTS + 1;
  localparam int CIRC_DEPTH  = MAX_EDGES + MAX_VERTS + 2;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int CIRC_AW     = $clog2(CIRC_DEPTH);
  localparam int CLEN_W      = $clog2(CIRC_DEPTH + 1);

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef cnt_t [NODES-1:0]   row_t;
  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [VIDX_W-1:0]  vidx_t;
  typedef logic [FIELD_W-1:0] field_t;

  // vertex count register screening: zero reads as one, large values saturate
  function automatic field_t vcount_clamp(input field_t v);
    field_t r;
    r = v;
    if (v == field_t'(0)) begin
      r = field_t'(1);
    end else if (v > field_t'(MAX_VERTS)) begin
      r = field_t'(MAX_VERTS);
    end
    return r;
  endfunction

endpackage

// ===== src/minimum_trail_cover_euler.sv =====
// Minimum trail cover of an undirected multigraph. Edges stream in one item
// at a time (end_a, end_b, 1-based); an edge with an endpoint of zero or above
// vertex_count, or beyond the edge capacity, is dropped, and tlast on any item
// starts the computation. Odd-degree vertices are tied to a virtual vertex,
// an Euler circuit is walked from vertex 1 taking the smallest neighbor first,
// and the circuit is cut at the virtual vertex into the fewest trails. Each
// result item is one vertex: tdata carries the trail count, trail index and
// vertex, tuser marks the last vertex of a trail and tlast the final item.
// A graph with all even degrees yields one closed trail. A loaded edge other
// than a self-loop updates two rows of the 17-row adjacency memory through
// its single read and single write port, a self-loop only one. The flagged
// item then holds the input through the degree parity pass, the walk, which
// uses the edges and pushes and pops the walk stack, and the output of the
// circuit entries as results, which waits while the result side stalls. The
// graph is cleared when the final result is handed to the output register.
module minimum_trail_cover_euler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] end_a, [9:5] end_b, [15:10] zero
  input  logic        in_tlast,   // last_edge
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] trail_total, [6:4] trail_number,
                                  // [11:7] vertex, [15:12] zero
  output logic        out_tuser,  // trail_end
  output logic        out_tlast   // last
);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LD_RDA   = 4'd1;
  localparam logic [3:0] S_LD_WRA   = 4'd2;
  localparam logic [3:0] S_LD_WRB   = 4'd3;
  localparam logic [3:0] S_DG_RD    = 4'd4;
  localparam logic [3:0] S_DG_WR    = 4'd5;
  localparam logic [3:0] S_DG_VIRT  = 4'd6;
  localparam logic [3:0] S_WK_RD    = 4'd7;
  localparam logic [3:0] S_WK_SCAN  = 4'd8;
  localparam logic [3:0] S_WK_DEC   = 4'd9;
  localparam logic [3:0] S_WK_POP   = 4'd10;
  localparam logic [3:0] S_EM_SET   = 4'd11;
  localparam logic [3:0] S_EM_RD    = 4'd12;
  localparam logic [3:0] S_EM_PROC  = 4'd13;
  localparam logic [3:0] S_EM_FLUSH = 4'd14;
  localparam logic [3:0] S_CLEAR    = 4'd15;

  // control registers
  logic [3:0]                        state_r, state_nxt;
  mtce_pkg::field_t                  vcount_r, vcount_nxt;
  logic [mtce_pkg::EDGE_W-1:0]       edges_r, edges_nxt;
  logic [mtce_pkg::NODES-1:0]        adj_vld_r;
  logic                              out_valid_r, out_valid_nxt;
  logic                              pend_v_r, pend_v_nxt;

  // working registers
  mtce_pkg::node_t                   a_r, a_nxt, b_r, b_nxt;
  logic                              lastin_r, lastin_nxt;
  mtce_pkg::vidx_t                   dv_r, dv_nxt;
  logic [mtce_pkg::MAX_VERTS-1:0]    odd_mask_r, odd_mask_nxt;
  mtce_pkg::node_t                   top_r, top_nxt, prev_r, prev_nxt;
  logic [mtce_pkg::SP_W-1:0]         sp_r, sp_nxt;
  logic [mtce_pkg::CLEN_W-1:0]       clen_r, clen_nxt, start_r, start_nxt;
  logic [mtce_pkg::CLEN_W-1:0]       len_r, len_nxt, rem_r, rem_nxt;
  logic [mtce_pkg::TOTAL_W-1:0]      total_r, total_nxt, tot_r, tot_nxt;
  logic                              seen_r, seen_nxt, odd_r, odd_nxt;
  logic [mtce_pkg::CIRC_AW-1:0]      ptr_r, ptr_nxt;
  logic [mtce_pkg::TRAIL_W-1:0]      trail_r, trail_nxt;
  logic [mtce_pkg::TRAIL_W-1:0]      pend_trail_r, pend_trail_nxt;
  mtce_pkg::node_t                   pend_vx_r, pend_vx_nxt;
  logic                              pend_te_r, pend_te_nxt;

  // output payload registers
  logic [mtce_pkg::TOTAL_W-1:0]      out_total_r, out_total_nxt;
  logic [mtce_pkg::TRAIL_W-1:0]      out_trail_r, out_trail_nxt;
  mtce_pkg::field_t                  out_vertex_r, out_vertex_nxt;
  logic                              out_te_r, out_te_nxt;
  logic                              out_last_r, out_last_nxt;

  // adjacency row memory
  mtce_pkg::row_t                    adj_mem [mtce_pkg::NODES];
  mtce_pkg::row_t                    adj_rd_r;
  logic                              adj_rv_r;
  logic                              adj_re, adj_we, adj_clr;
  mtce_pkg::node_t                   adj_raddr, adj_waddr;
  mtce_pkg::row_t                    adj_wrow, eff_row, mod_row, virt_row;
  mtce_pkg::node_t                   mod_col;
  mtce_pkg::cnt_t                    mod_amt;
  logic                              mod_dec;

  // walk stack and circuit memories
  mtce_pkg::node_t                   stk_mem [mtce_pkg::STACK_DEPTH];
  mtce_pkg::node_t                   stk_rd_r;
  logic                              stk_re, stk_we;
  logic [mtce_pkg::STK_AW-1:0]       stk_raddr, stk_waddr;
  mtce_pkg::node_t                   circ_mem [mtce_pkg::CIRC_DEPTH];
  mtce_pkg::node_t                   circ_rd_r;
  logic                              circ_re, circ_we;
  logic [mtce_pkg::CIRC_AW-1:0]      circ_raddr, circ_waddr;

  // row scan results
  logic                              deg_par;
  logic                              scan_found;
  mtce_pkg::node_t                   scan_u;

  // helpers of the sequencer
  logic                              out_free;
  mtce_pkg::field_t                  in_a, in_b;
  logic                              in_ok;
  logic [mtce_pkg::CLEN_W-1:0]       em_len;

  // a row never written reads as all zero
  assign eff_row  = adj_rv_r ? adj_rd_r : '0;
  assign out_free = !out_valid_r || out_tready;
  assign in_a     = in_tdata[4:0];
  assign in_b     = in_tdata[9:5];
  assign in_ok    = (in_a != '0) && (in_a <= vcount_r) && (in_b != '0) &&
                    (in_b <= vcount_r) &&
                    (edges_r < mtce_pkg::EDGE_W'(mtce_pkg::MAX_EDGES));

  // one-entry add or subtract on the row just read
  always_comb begin
    mod_row = eff_row;
    if (mod_dec) begin
      mod_row[mod_col] = eff_row[mod_col] - mod_amt;
    end else begin
      mod_row[mod_col] = eff_row[mod_col] + mod_amt;
    end
  end

  // virtual vertex row built from the odd-degree mask
  always_comb begin
    virt_row = '0;
    for (int j = 0; j < mtce_pkg::MAX_VERTS; j++) begin
      virt_row[j] = mtce_pkg::cnt_t'(odd_mask_r[j]);
    end
  end

  // degree parity over the real columns
  always_comb begin
    deg_par = 1'b0;
    for (int j = 0; j < mtce_pkg::MAX_VERTS; j++) begin
      deg_par = deg_par ^ eff_row[j][0];
    end
  end

  // smallest neighbor with an unused edge
  always_comb begin
    scan_found = 1'b0;
    scan_u     = '0;
    for (int j = mtce_pkg::NODES - 1; j >= 0; j--) begin
      if (eff_row[j] != '0) begin
        scan_found = 1'b1;
        scan_u     = mtce_pkg::node_t'(j);
      end
    end
  end

  // sequencer
  always_comb begin
    em_len         = clen_r - mtce_pkg::CLEN_W'(1);
    state_nxt      = state_r;
    vcount_nxt     = vcount_r;
    edges_nxt      = edges_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    lastin_nxt     = lastin_r;
    dv_nxt         = dv_r;
    odd_mask_nxt   = odd_mask_r;
    top_nxt        = top_r;
    prev_nxt       = prev_r;
    sp_nxt         = sp_r;
    clen_nxt       = clen_r;
    start_nxt      = start_r;
    len_nxt        = len_r;
    rem_nxt        = rem_r;
    total_nxt      = total_r;
    tot_nxt        = tot_r;
    seen_nxt       = seen_r;
    odd_nxt        = odd_r;
    ptr_nxt        = ptr_r;
    trail_nxt      = trail_r;
    pend_v_nxt     = pend_v_r;
    pend_trail_nxt = pend_trail_r;
    pend_vx_nxt    = pend_vx_r;
    pend_te_nxt    = pend_te_r;
    out_valid_nxt  = out_valid_r;
    out_total_nxt  = out_total_r;
    out_trail_nxt  = out_trail_r;
    out_vertex_nxt = out_vertex_r;
    out_te_nxt     = out_te_r;
    out_last_nxt   = out_last_r;
    adj_re         = 1'b0;
    adj_raddr      = top_r;
    adj_we         = 1'b0;
    adj_waddr      = top_r;
    adj_wrow       = mod_row;
    adj_clr        = 1'b0;
    mod_col        = '0;
    mod_amt        = mtce_pkg::cnt_t'(1);
    mod_dec        = 1'b0;
    stk_re         = 1'b0;
    stk_raddr      = mtce_pkg::STK_AW'(sp_r - mtce_pkg::SP_W'(2));
    stk_we         = 1'b0;
    stk_waddr      = mtce_pkg::STK_AW'(sp_r - mtce_pkg::SP_W'(1));
    circ_re        = 1'b0;
    circ_raddr     = ptr_r;
    circ_we        = 1'b0;
    circ_waddr     = mtce_pkg::CIRC_AW'(clen_r);
    in_tready      = 1'b0;

    // configuration write
    if (cfg_we) begin
      vcount_nxt = mtce_pkg::vcount_clamp(cfg_wdata);
    end

    // result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // accept an edge item
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          a_nxt      = mtce_pkg::node_t'(in_a - mtce_pkg::field_t'(1));
          b_nxt      = mtce_pkg::node_t'(in_b - mtce_pkg::field_t'(1));
          lastin_nxt = in_tlast;
          if (in_ok) begin
            edges_nxt = edges_r + mtce_pkg::EDGE_W'(1);
            state_nxt = S_LD_RDA;
          end else if (in_tlast) begin
            dv_nxt       = '0;
            odd_mask_nxt = '0;
            state_nxt    = S_DG_RD;
          end
        end
      end

      // add the edge to row a, then to row b unless it is a self-loop
      S_LD_RDA: begin
        adj_re    = 1'b1;
        adj_raddr = a_r;
        state_nxt = S_LD_WRA;
      end

      S_LD_WRA: begin
        mod_col   = b_r;
        mod_amt   = (a_r == b_r) ? mtce_pkg::cnt_t'(2) : mtce_pkg::cnt_t'(1);
        adj_we    = 1'b1;
        adj_waddr = a_r;
        if (a_r != b_r) begin
          adj_re    = 1'b1;
          adj_raddr = b_r;
          state_nxt = S_LD_WRB;
        end else if (lastin_r) begin
          dv_nxt       = '0;
          odd_mask_nxt = '0;
          state_nxt    = S_DG_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_LD_WRB: begin
        mod_col   = a_r;
        adj_we    = 1'b1;
        adj_waddr = b_r;
        if (lastin_r) begin
          dv_nxt       = '0;
          odd_mask_nxt = '0;
          state_nxt    = S_DG_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // degree parity pass, tie odd vertices to the virtual vertex
      S_DG_RD: begin
        adj_re    = 1'b1;
        adj_raddr = mtce_pkg::node_t'(dv_r);
        state_nxt = S_DG_WR;
      end

      S_DG_WR: begin
        mod_col            = mtce_pkg::node_t'(mtce_pkg::VIRT);
        mod_amt            = mtce_pkg::cnt_t'(deg_par);
        adj_we             = 1'b1;
        adj_waddr          = mtce_pkg::node_t'(dv_r);
        odd_mask_nxt[dv_r] = deg_par;
        if (dv_r == mtce_pkg::vidx_t'(mtce_pkg::MAX_VERTS - 1)) begin
          state_nxt = S_DG_VIRT;
        end else begin
          dv_nxt    = dv_r + mtce_pkg::vidx_t'(1);
          state_nxt = S_DG_RD;
        end
      end

      S_DG_VIRT: begin
        adj_we    = 1'b1;
        adj_waddr = mtce_pkg::node_t'(mtce_pkg::VIRT);
        adj_wrow  = virt_row;
        top_nxt   = '0;
        sp_nxt    = mtce_pkg::SP_W'(1);
        clen_nxt  = '0;
        total_nxt = '0;
        start_nxt = '0;
        seen_nxt  = 1'b0;
        state_nxt = S_WK_RD;
      end

      // walk: read the row of the vertex on top of the stack
      S_WK_RD: begin
        adj_re    = 1'b1;
        adj_raddr = top_r;
        state_nxt = S_WK_SCAN;
      end

      S_WK_SCAN: begin
        if (scan_found) begin
          // use one edge top-u and push u
          mod_col   = scan_u;
          mod_amt   = (scan_u == top_r) ? mtce_pkg::cnt_t'(2) : mtce_pkg::cnt_t'(1);
          mod_dec   = 1'b1;
          adj_we    = 1'b1;
          adj_waddr = top_r;
          stk_we    = 1'b1;
          sp_nxt    = sp_r + mtce_pkg::SP_W'(1);
          if (scan_u == top_r) begin
            state_nxt = S_WK_RD;
          end else begin
            adj_re    = 1'b1;
            adj_raddr = scan_u;
            prev_nxt  = top_r;
            top_nxt   = scan_u;
            state_nxt = S_WK_DEC;
          end
        end else begin
          // dead end: pop into the circuit
          circ_we  = 1'b1;
          clen_nxt = clen_r + mtce_pkg::CLEN_W'(1);
          sp_nxt   = sp_r - mtce_pkg::SP_W'(1);
          if (top_r == mtce_pkg::node_t'(mtce_pkg::VIRT)) begin
            seen_nxt = 1'b1;
            if (clen_r != '0) begin
              total_nxt = total_r + mtce_pkg::TOTAL_W'(1);
              if (total_r == '0) begin
                start_nxt = clen_r;
              end
            end
          end
          if (sp_r == mtce_pkg::SP_W'(1)) begin
            state_nxt = S_EM_SET;
          end else begin
            stk_re    = 1'b1;
            state_nxt = S_WK_POP;
          end
        end
      end

      // mirror entry in the neighbor's row
      S_WK_DEC: begin
        mod_col   = prev_r;
        mod_dec   = 1'b1;
        adj_we    = 1'b1;
        adj_waddr = top_r;
        state_nxt = S_WK_RD;
      end

      S_WK_POP: begin
        top_nxt   = stk_rd_r;
        state_nxt = S_WK_RD;
      end

      // choose circuit order: rotated at the virtual vertex or as walked
      S_EM_SET: begin
        trail_nxt  = '0;
        pend_v_nxt = 1'b0;
        len_nxt    = em_len;
        if ((odd_mask_r != '0) && seen_r) begin
          odd_nxt = 1'b1;
          tot_nxt = total_r;
          rem_nxt = em_len - mtce_pkg::CLEN_W'(1);
          if (start_r == em_len) begin
            ptr_nxt = mtce_pkg::CIRC_AW'(1);
          end else begin
            ptr_nxt = mtce_pkg::CIRC_AW'(start_r + mtce_pkg::CLEN_W'(1));
          end
        end else begin
          odd_nxt = 1'b0;
          tot_nxt = mtce_pkg::TOTAL_W'(1);
          rem_nxt = clen_r;
          ptr_nxt = '0;
        end
        state_nxt = S_EM_RD;
      end

      S_EM_RD: begin
        if (rem_r == '0) begin
          state_nxt = S_EM_FLUSH;
        end else begin
          circ_re = 1'b1;
          rem_nxt = rem_r - mtce_pkg::CLEN_W'(1);
          if (odd_r && (mtce_pkg::CLEN_W'(ptr_r) == len_r)) begin
            ptr_nxt = mtce_pkg::CIRC_AW'(1);
          end else begin
            ptr_nxt = ptr_r + mtce_pkg::CIRC_AW'(1);
          end
          state_nxt = S_EM_PROC;
        end
      end

      // one entry held back so the trail end can still be marked
      S_EM_PROC: begin
        if (circ_rd_r == mtce_pkg::node_t'(mtce_pkg::VIRT)) begin
          pend_te_nxt = 1'b1;
          trail_nxt   = trail_r + mtce_pkg::TRAIL_W'(1);
          state_nxt   = S_EM_RD;
        end else if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_total_nxt  = tot_r;
            out_trail_nxt  = pend_trail_r;
            out_vertex_nxt = mtce_pkg::field_t'(pend_vx_r) + mtce_pkg::field_t'(1);
            out_te_nxt     = pend_te_r;
            out_last_nxt   = 1'b0;
          end
          pend_v_nxt     = 1'b1;
          pend_trail_nxt = trail_r;
          pend_vx_nxt    = circ_rd_r;
          pend_te_nxt    = 1'b0;
          state_nxt      = S_EM_RD;
        end
      end

      S_EM_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_CLEAR;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_total_nxt  = tot_r;
          out_trail_nxt  = pend_trail_r;
          out_vertex_nxt = mtce_pkg::field_t'(pend_vx_r) + mtce_pkg::field_t'(1);
          out_te_nxt     = 1'b1;
          out_last_nxt   = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_CLEAR;
        end
      end

      // drop the graph for the next load
      S_CLEAR: begin
        adj_clr   = 1'b1;
        edges_nxt = '0;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= mtce_pkg::field_t'(mtce_pkg::MAX_VERTS);
      edges_r     <= '0;
      adj_vld_r   <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      sp_r        <= '0;
      clen_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      edges_r     <= edges_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      sp_r        <= sp_nxt;
      clen_r      <= clen_nxt;
      if (adj_clr) begin
        adj_vld_r <= '0;
      end else if (adj_we) begin
        adj_vld_r[adj_waddr] <= 1'b1;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    lastin_r     <= lastin_nxt;
    dv_r         <= dv_nxt;
    odd_mask_r   <= odd_mask_nxt;
    top_r        <= top_nxt;
    prev_r       <= prev_nxt;
    start_r      <= start_nxt;
    len_r        <= len_nxt;
    rem_r        <= rem_nxt;
    total_r      <= total_nxt;
    tot_r        <= tot_nxt;
    seen_r       <= seen_nxt;
    odd_r        <= odd_nxt;
    ptr_r        <= ptr_nxt;
    trail_r      <= trail_nxt;
    pend_trail_r <= pend_trail_nxt;
    pend_vx_r    <= pend_vx_nxt;
    pend_te_r    <= pend_te_nxt;
    out_total_r  <= out_total_nxt;
    out_trail_r  <= out_trail_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_te_r     <= out_te_nxt;
    out_last_r   <= out_last_nxt;
  end

  // adjacency memory, one row read and one row write per cycle
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wrow;
    end
    if (adj_re) begin
      adj_rd_r <= adj_mem[adj_raddr];
      adj_rv_r <= adj_vld_r[adj_raddr];
    end
  end

  // walk stack memory, entries below the top register
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= top_r;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  // circuit memory
  always_ff @(posedge clk) begin
    if (circ_we) begin
      circ_mem[circ_waddr] <= top_r;
    end
    if (circ_re) begin
      circ_rd_r <= circ_mem[circ_raddr];
    end
  end

  // result port
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_vertex_r, out_trail_r, out_total_r};
  assign out_tuser  = out_te_r;
  assign out_tlast  = out_last_r;

  // stack never grows past its storage
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_r <= mtce_pkg::SP_W'(mtce_pkg::STACK_DEPTH)) || (state_r == S_IDLE))
    else $error("walk stack overflow");

  // circuit never grows past its storage
  a_clen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (clen_r < mtce_pkg::CLEN_W'(mtce_pkg::CIRC_DEPTH)) || (state_r == S_IDLE))
    else $error("circuit buffer overflow");

  // final item always closes its trail
  a_last_ends_trail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("final item without trail end");

  // trail index stays below the trail count
  a_trail_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_trail_r} < out_total_r))
    else $error("trail index out of range");

  // no held-back result while new edges are taken
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_v_r)
    else $error("pending result left when accepting edges");

endmodule
